@@ hdl/muon_burst_unpack_check_assert.svh @@
// ----------------------------------------------------------------------------
// Muon burst unpack check assertion macros
// Concurrent assertion wrappers, clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef MUON_BURST_UNPACK_CHECK_ASSERT_SVH
`define MUON_BURST_UNPACK_CHECK_ASSERT_SVH

`ifndef SYNTHESIS
`define MBUC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("muon_burst_unpack_check: assertion failed");
`define MBUC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("muon_burst_unpack_check: assertion failed");
`else
`define MBUC_ASSERT_SAME(label, ante, cons)
`define MBUC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ hdl/mbuc_pkg.sv @@
// ----------------------------------------------------------------------------
// Muon burst unpack check package
// Types, register map and status codes shared by the burst unpacker.
// ----------------------------------------------------------------------------
`default_nettype none

package mbuc_pkg;

    localparam int ADC_BITS_DEFAULT = 12;
    localparam int ADC_OUT_W        = 12;
    localparam int SEQ_W            = 7;
    localparam int COUNT_W          = 16;
    localparam int TAG_W            = 31;
    localparam int PADDR_W          = 3;

    localparam logic [SEQ_W-1:0] BURST_SAMPLES_RESET = 7'd19;
    localparam logic [SEQ_W-1:0] INDEX_MAX           = 7'd127;

    typedef enum logic [0:0] {
        REG_BURST_SAMPLES = 1'b0
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_SEQ_MISMATCH = 2'd1,
        ST_NO_HEADER    = 2'd2,
        ST_BEYOND_BURST = 2'd3
    } status_t;

    typedef struct packed {
        logic                  is_header;
        logic [TAG_W-1:0]      burst_time;
        logic [TAG_W-1:0]      trigger_tag;
        logic [ADC_OUT_W-1:0]  adc_ch0;
        logic [ADC_OUT_W-1:0]  adc_ch1;
        logic [ADC_OUT_W-1:0]  adc_ch2;
        logic [ADC_OUT_W-1:0]  adc_ch3;
        logic [SEQ_W-1:0]      seq_value;
        logic [SEQ_W-1:0]      sample_index;
        logic [COUNT_W-1:0]    burst_count;
        status_t               sample_status;
        logic                  burst_bad;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/muon_burst_unpack_check.sv @@
// ----------------------------------------------------------------------------
// Muon burst unpack check
// Unpacks header and sample word pairs of a muon burst buffer and checks
// the sample sequence numbers against their position in the burst.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                 Payload
//  in       input      in_valid / in_stall       word_lo, word_hi, last_word
//  out      output     out_valid / out_stall     is_header .. burst_bad
//  cfg      input      APB psel/penable/pready   paddr, pwdata, prdata
//
// One word pair is accepted per cycle unless stalled; the result is registered.
// The burst state is updated by the single register stage at acceptance.
// A stalled result is held in the output register and one more word goes to
// a skid register; in_stall rises only while that skid register is full.
// Reset clears the burst state, the handshake state and sets burst_samples
// to 19.
// ----------------------------------------------------------------------------
`default_nettype none

module muon_burst_unpack_check
    import mbuc_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [31:0]           word_lo,
    input  wire logic [31:0]           word_hi,
    input  wire logic                  last_word,

    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       is_header,
    output logic [TAG_W-1:0]           burst_time,
    output logic [TAG_W-1:0]           trigger_tag,
    output logic [ADC_OUT_W-1:0]       adc_ch0,
    output logic [ADC_OUT_W-1:0]       adc_ch1,
    output logic [ADC_OUT_W-1:0]       adc_ch2,
    output logic [ADC_OUT_W-1:0]       adc_ch3,
    output logic [SEQ_W-1:0]           seq_value,
    output logic [SEQ_W-1:0]           sample_index,
    output logic [COUNT_W-1:0]         burst_count,
    output logic [1:0]                 sample_status,
    output logic                       burst_bad,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_W-1:0]    paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int AdcKeep = (ADC_BITS < ADC_OUT_W) ? ADC_BITS : ADC_OUT_W;
    localparam logic [ADC_OUT_W-1:0] AdcMask = ADC_OUT_W'((33'd1 << AdcKeep) - 33'd1);

    logic [SEQ_W-1:0]    burst_samples_reg;
    logic                header_seen_reg, header_seen_next;
    logic [COUNT_W-1:0]  headers_reg, headers_next;
    logic [SEQ_W-1:0]    index_reg, index_next;
    logic                corrupt_reg, corrupt_next;

    logic                out_valid_reg;
    result_t             out_data_reg;
    logic                skid_valid_reg;
    result_t             skid_data_reg;

    logic                in_accept;
    logic                cfg_write;
    reg_index_t          cfg_index;
    result_t             res;
    logic [SEQ_W-1:0]    seq;
    logic [SEQ_W:0]      expected_seq;

    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_index = reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        unique case (cfg_index)
            REG_BURST_SAMPLES: prdata = {25'd0, burst_samples_reg};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_samples_reg <= BURST_SAMPLES_RESET;
        end
        else if (cfg_write && (cfg_index == REG_BURST_SAMPLES))
        begin
            burst_samples_reg <= pwdata[SEQ_W-1:0];
        end
    end

    // Word unpacking and sequence check
    assign seq          = {word_hi[30:28], word_hi[15:12]};
    assign expected_seq = {1'b0, index_reg} + 8'd1;

    always_comb
    begin
        res              = '0;
        header_seen_next = header_seen_reg;
        headers_next     = headers_reg;
        index_next       = index_reg;
        corrupt_next     = corrupt_reg;

        if (word_lo[31])
        begin
            headers_next     = headers_reg + 16'd1;
            header_seen_next = 1'b1;
            index_next       = '0;
            corrupt_next     = 1'b0;
            res.is_header    = 1'b1;
            res.burst_time   = word_lo[30:0];
            res.trigger_tag  = word_hi[30:0];
            res.burst_count  = headers_next;
        end
        else
        begin
            res.adc_ch0   = word_lo[11:0] & AdcMask;
            res.adc_ch1   = word_lo[27:16] & AdcMask;
            res.adc_ch2   = word_hi[11:0] & AdcMask;
            res.adc_ch3   = word_hi[27:16] & AdcMask;
            res.seq_value = seq;
            if (!header_seen_reg)
            begin
                res.sample_status = ST_NO_HEADER;
            end
            else
            begin
                res.sample_index = index_reg;
                if (index_reg >= burst_samples_reg)
                begin
                    res.sample_status = ST_BEYOND_BURST;
                end
                else if ({1'b0, seq} != expected_seq)
                begin
                    res.sample_status = ST_SEQ_MISMATCH;
                    corrupt_next      = 1'b1;
                end
                else
                begin
                    res.sample_status = ST_OK;
                end
                if (index_reg != INDEX_MAX)
                begin
                    index_next = index_reg + 7'd1;
                end
            end
            res.burst_count = headers_reg;
            res.burst_bad   = corrupt_next;
        end

        if (last_word)
        begin
            header_seen_next = 1'b0;
            headers_next     = '0;
            index_next       = '0;
            corrupt_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_seen_reg <= 1'b0;
            headers_reg     <= '0;
            index_reg       <= '0;
            corrupt_reg     <= 1'b0;
        end
        else if (in_accept)
        begin
            header_seen_reg <= header_seen_next;
            headers_reg     <= headers_next;
            index_reg       <= index_next;
            corrupt_reg     <= corrupt_next;
        end
    end

    // Output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_accept;
            end
        end
        else if (in_accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (in_accept)
            begin
                out_data_reg <= res;
            end
        end
        else if (in_accept)
        begin
            skid_data_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign is_header     = out_data_reg.is_header;
    assign burst_time    = out_data_reg.burst_time;
    assign trigger_tag   = out_data_reg.trigger_tag;
    assign adc_ch0       = out_data_reg.adc_ch0;
    assign adc_ch1       = out_data_reg.adc_ch1;
    assign adc_ch2       = out_data_reg.adc_ch2;
    assign adc_ch3       = out_data_reg.adc_ch3;
    assign seq_value     = out_data_reg.seq_value;
    assign sample_index  = out_data_reg.sample_index;
    assign burst_count   = out_data_reg.burst_count;
    assign sample_status = out_data_reg.sample_status;
    assign burst_bad     = out_data_reg.burst_bad;

    `include "muon_burst_unpack_check_assert.svh"

    `MBUC_ASSERT_SAME(a_skid_implies_out, skid_valid_reg, out_valid_reg)
    `MBUC_ASSERT_NEXT(a_accept_gives_result, in_accept && !out_valid_reg, out_valid_reg)
    `MBUC_ASSERT_SAME(a_no_header_state_clear, !header_seen_reg,
                      (index_reg == '0) && !corrupt_reg)
    `MBUC_ASSERT_SAME(a_header_result_clean, out_valid_reg && out_data_reg.is_header,
                      (out_data_reg.sample_status == ST_OK) && !out_data_reg.burst_bad)

endmodule

`default_nettype wire
